// ===== hdl/sha1_block_compression_top_assert.svh =====
// ---------------------------------------------------------------------------
// SHA-1 block compression assertion macros
// Concurrent assertion helpers shared by the compression engine modules.
// ---------------------------------------------------------------------------
`ifndef SHA1_BLOCK_COMPRESSION_TOP_ASSERT_SVH
`define SHA1_BLOCK_COMPRESSION_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define SHA1BC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sha1 block compression: assertion failed");

// Next-cycle implication.
`define SHA1BC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sha1 block compression: assertion failed");

`else

`define SHA1BC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SHA1BC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/sha1bc_pkg.sv =====
// ---------------------------------------------------------------------------
// SHA-1 block compression package
// Types, constants and round helper functions shared by the engine modules.
// ---------------------------------------------------------------------------
package sha1bc_pkg;

   localparam int unsigned NUM_WORDS = 16;
   localparam int unsigned CV_WORDS  = 5;

   typedef logic [31:0]                word_type;
   typedef logic [CV_WORDS-1:0][31:0]  cv_type;
   typedef logic [6:0]                 round_type;
   typedef logic [3:0]                 pos_type;
   typedef logic [2:0]                 index_type;

   localparam round_type LAST_ROUND = 7'd79;
   localparam pos_type   LAST_POS   = 4'd15;
   localparam pos_type   FIRST_POS  = 4'd0;
   localparam index_type FIRST_INDEX = 3'd0;
   localparam index_type LAST_INDEX  = 3'd4;

   localparam word_type K_ROUND_0 = 32'h5A827999;
   localparam word_type K_ROUND_1 = 32'h6ED9EBA1;
   localparam word_type K_ROUND_2 = 32'h8F1BBCDC;
   localparam word_type K_ROUND_3 = 32'hCA62C1D6;

   // Element 0 is H0.
   localparam cv_type INIT_VALUE = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                    32'hEFCDAB89, 32'h67452301};

   typedef struct packed {
      logic word_en;
      logic start;
   } core_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_status_type;

   function automatic word_type round_func(round_type r, word_type b, word_type c,
                                           word_type d);
      word_type f;
      if (r < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (r < 7'd40) begin
         f = b ^ c ^ d;
      end else if (r < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

   function automatic word_type round_const(round_type r);
      word_type k;
      if (r < 7'd20) begin
         k = K_ROUND_0;
      end else if (r < 7'd40) begin
         k = K_ROUND_1;
      end else if (r < 7'd60) begin
         k = K_ROUND_2;
      end else begin
         k = K_ROUND_3;
      end
      return k;
   endfunction

endpackage

// ===== hdl/sha1bc_core.sv =====
// ---------------------------------------------------------------------------
// SHA-1 round core
// Holds the sixteen-word schedule window and the working words, and runs
// one shared round unit through the 80 rounds of each block.
// ---------------------------------------------------------------------------
`include "sha1_block_compression_top_assert.svh"

module sha1bc_core (
   input  logic                         clock,
   input  logic                         reset,
   input  sha1bc_pkg::core_ctrl_type    ctrl,
   input  sha1bc_pkg::word_type         word_in,
   input  sha1bc_pkg::cv_type           cv_start,
   output sha1bc_pkg::core_status_type  status,
   output sha1bc_pkg::cv_type           work
);
   import sha1bc_pkg::*;

   typedef enum logic {
      CORE_IDLE,
      CORE_RUN
   } core_state_type;

   core_state_type state_ff, state_in;
   round_type      round_ff, round_in;
   logic           done_ff, done_in;
   word_type       sched_ff [NUM_WORDS];
   word_type       sched_in [NUM_WORDS];
   cv_type         work_ff, work_in;

   word_type       temp;
   word_type       expand;

   always_comb begin
      temp = {work_ff[0][26:0], work_ff[0][31:27]}
           + round_func(round_ff, work_ff[1], work_ff[2], work_ff[3])
           + work_ff[4] + sched_ff[0] + round_const(round_ff);
      expand = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
      expand = {expand[30:0], expand[31]};
   end

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      done_in  = 1'b0;
      sched_in = sched_ff;
      work_in  = work_ff;
      unique case (state_ff)
         CORE_IDLE: begin
            if (ctrl.word_en) begin
               for (int i = 0; i < NUM_WORDS - 1; i++) begin
                  sched_in[i] = sched_ff[i+1];
               end
               sched_in[NUM_WORDS-1] = word_in;
            end
            if (ctrl.start) begin
               work_in  = cv_start;
               round_in = '0;
               state_in = CORE_RUN;
            end
         end
         CORE_RUN: begin
            work_in[0] = temp;
            work_in[1] = work_ff[0];
            work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
            work_in[3] = work_ff[2];
            work_in[4] = work_ff[3];
            // The window slides by one word; the new tail is the expanded word.
            for (int i = 0; i < NUM_WORDS - 1; i++) begin
               sched_in[i] = sched_ff[i+1];
            end
            sched_in[NUM_WORDS-1] = expand;
            round_in = round_ff + 7'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = CORE_IDLE;
               done_in  = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORE_IDLE;
         round_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sched_ff <= sched_in;
      work_ff  <= work_in;
   end

   assign status.busy = (state_ff == CORE_RUN);
   assign status.done = done_ff;
   assign work        = work_ff;

   `SHA1BC_ASSERT_IMPLY(a_round_range, clock, reset, state_ff == CORE_RUN, round_ff <= LAST_ROUND)
   `SHA1BC_ASSERT_NEXT(a_done_after_last, clock, reset,
      state_ff == CORE_RUN && round_ff == LAST_ROUND, done_ff && state_ff == CORE_IDLE)
   `SHA1BC_ASSERT_IMPLY(a_done_when_idle, clock, reset, done_ff, state_ff == CORE_IDLE)

endmodule

// ===== hdl/sha1_block_compression_top.sv =====
// ---------------------------------------------------------------------------
// SHA-1 block compression engine
// Collects padded message words sixteen to a block, compresses each block
// into the chaining value and returns the five digest words on request.
// ---------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  req     | in        | req_valid/stall  | message_word, message_start, message_end
//  rsp     | out       | rsp_valid/stall  | digest_word, digest_index, digest_last
//
// Words one to fifteen of a block are taken while req_stall is low. The
// sixteenth word starts 80 rounds on the shared round unit, one round a
// cycle; when the core signals done, the result is added into the chaining
// value. With an end flag, five digest items follow, one per cycle unless
// rsp_stall holds them. req_stall is high while rounds run or digest items
// are pending. Reset is synchronous and loads the initial hash value.
// ---------------------------------------------------------------------------
`include "sha1_block_compression_top_assert.svh"

module sha1_block_compression_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  sha1bc_pkg::word_type        req_message_word,
   input  logic                        req_message_start,
   input  logic                        req_message_end,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output sha1bc_pkg::word_type        rsp_digest_word,
   output sha1bc_pkg::index_type       rsp_digest_index,
   output logic                        rsp_digest_last
);
   import sha1bc_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ROUND,
      S_OUT
   } state_type;

   state_type        state_ff, state_in;
   pos_type          pos_ff, pos_in;
   logic             reload_ff, reload_in;
   logic             end_ff, end_in;
   index_type        idx_ff, idx_in;
   cv_type           cv_ff, cv_in;

   logic             req_accept;
   logic             rsp_accept;
   core_ctrl_type    core_ctrl;
   core_status_type  core_status;
   cv_type           cv_start;
   cv_type           work;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign cv_start   = reload_ff ? INIT_VALUE : cv_ff;

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      reload_in = reload_ff;
      end_in    = end_ff;
      idx_in    = idx_ff;
      cv_in     = cv_ff;
      core_ctrl = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               core_ctrl.word_en = 1'b1;
               pos_in = pos_ff + 4'd1;
               if (pos_ff == FIRST_POS && req_message_start) begin
                  reload_in = 1'b1;
               end
               if (pos_ff == LAST_POS) begin
                  core_ctrl.start = 1'b1;
                  end_in    = req_message_end;
                  reload_in = 1'b0;
                  cv_in     = cv_start;
                  state_in  = S_ROUND;
               end
            end
         end
         S_ROUND: begin
            if (core_status.done) begin
               for (int i = 0; i < CV_WORDS; i++) begin
                  cv_in[i] = cv_ff[i] + work[i];
               end
               idx_in   = FIRST_INDEX;
               state_in = end_ff ? S_OUT : S_IDLE;
            end
         end
         S_OUT: begin
            if (rsp_accept) begin
               if (idx_ff == LAST_INDEX) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pos_ff    <= '0;
         reload_ff <= 1'b1;
         end_ff    <= 1'b0;
         idx_ff    <= '0;
         cv_ff     <= INIT_VALUE;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         reload_ff <= reload_in;
         end_ff    <= end_in;
         idx_ff    <= idx_in;
         cv_ff     <= cv_in;
      end
   end

   sha1bc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (core_ctrl),
      .word_in  (req_message_word),
      .cv_start (cv_start),
      .status   (core_status),
      .work     (work)
   );

   assign rsp_valid        = (state_ff == S_OUT);
   assign rsp_digest_word  = cv_ff[idx_ff];
   assign rsp_digest_index = idx_ff;
   assign rsp_digest_last  = (idx_ff == LAST_INDEX);

   `SHA1BC_ASSERT_IMPLY(a_rsp_blocks_req, clock, reset, rsp_valid, req_stall)
   `SHA1BC_ASSERT_IMPLY(a_done_in_round, clock, reset, core_status.done, state_ff == S_ROUND)
   `SHA1BC_ASSERT_IMPLY(a_busy_in_round, clock, reset, core_status.busy, state_ff == S_ROUND)
   `SHA1BC_ASSERT_IMPLY(a_out_index, clock, reset, rsp_valid, idx_ff <= LAST_INDEX)

endmodule

// ===== bench/sha1_block_compression_checker.sv =====
// ---------------------------------------------------------------------------
// SHA-1 block compression checker
// Watches both channels of the engine, keeps its own SHA-1 chaining value
// and block store, predicts the digest items of every end-flagged block and
// compares each digest item that leaves the engine against the oldest one due.
// ---------------------------------------------------------------------------
module sha1_block_compression_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  sha1bc_pkg::word_type  req_message_word,
   input  logic                  req_message_start,
   input  logic                  req_message_end,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  sha1bc_pkg::word_type  rsp_digest_word,
   input  sha1bc_pkg::index_type rsp_digest_index,
   input  logic                  rsp_digest_last,
   output int                    mismatch_count,
   output int                    digests_owed
);
   import sha1bc_pkg::*;

   typedef struct packed {
      word_type  word;
      index_type index;
      logic      last;
   } digest_item_type;

   localparam word_type SHA1_IV [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                        32'h10325476, 32'hC3D2E1F0};

   word_type        chain [5];
   word_type        block [16];
   pos_type         fill_pos;
   logic            reload_due;
   digest_item_type digest_due [$];
   int              failures = 0;
   int              owed = 0;

   assign mismatch_count = failures;
   assign digests_owed   = owed;

   function automatic word_type rotl(word_type x, int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // Runs the 80 rounds over the stored block and folds them into the chain.
   function automatic void compress_block();
      word_type sched [80];
      word_type a, b, c, d, e, f, k, t;
      int       r;
      for (r = 0; r < 16; r++) sched[r] = block[r];
      for (r = 16; r < 80; r++)
         sched[r] = rotl(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (r = 0; r < 80; r++) begin
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = 32'h5A827999;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = 32'h6ED9EBA1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d;
            k = 32'hCA62C1D6;
         end
         t = rotl(a, 5) + f + e + sched[r] + k;
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      chain[0] = chain[0] + a;
      chain[1] = chain[1] + b;
      chain[2] = chain[2] + c;
      chain[3] = chain[3] + d;
      chain[4] = chain[4] + e;
   endfunction

   function automatic void absorb_word(word_type w, logic s, logic e);
      digest_item_type item;
      int              i;
      // The start flag only counts on a block's first word, the end flag
      // only on its last.
      if (fill_pos == FIRST_POS && s) reload_due = 1'b1;
      block[fill_pos] = w;
      if (fill_pos != LAST_POS) begin
         fill_pos = fill_pos + 1'b1;
         return;
      end
      fill_pos = FIRST_POS;
      if (reload_due) begin
         chain = SHA1_IV;
         reload_due = 1'b0;
      end
      compress_block();
      if (e) begin
         for (i = 0; i < 5; i++) begin
            item.word  = chain[i];
            item.index = index_type'(i);
            item.last  = (index_type'(i) == LAST_INDEX);
            digest_due = {digest_due, item};
         end
      end
   endfunction

   function automatic void report_mismatch(string what, digest_item_type want);
      failures++;
      if (failures <= 10)
         $display("digest item %s: expected %h/%0d/%0d, got %h/%0d/%0d", what,
                  want.word, want.index, want.last,
                  rsp_digest_word, rsp_digest_index, rsp_digest_last);
   endfunction

   always @(posedge clock) begin : watch
      digest_item_type want;
      if (reset) begin
         chain = SHA1_IV;
         fill_pos = FIRST_POS;
         reload_due = 1'b1;
         digest_due.delete();
      end else begin
         if (req_valid && !req_stall)
            absorb_word(req_message_word, req_message_start, req_message_end);
         if (rsp_valid && !rsp_stall) begin
            if (digest_due.size() == 0) begin
               want = '0;
               report_mismatch("with none due", want);
            end else begin
               want = digest_due.pop_front();
               if (rsp_digest_word !== want.word || rsp_digest_index !== want.index
                   || rsp_digest_last !== want.last)
                  report_mismatch("mismatch", want);
            end
         end
      end
      owed = digest_due.size();
   end

endmodule

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// SHA-1 block compression testbench
// Feeds padded message blocks with directed and random words and flags,
// stalls and idles both channels at random, and lets the checker compare
// every digest item with its own SHA-1 prediction.
// ---------------------------------------------------------------------------
module tb;
   import sha1bc_pkg::*;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   word_type  req_message_word;
   logic      req_message_start;
   logic      req_message_end;
   logic      rsp_valid;
   logic      rsp_stall;
   word_type  rsp_digest_word;
   index_type rsp_digest_index;
   logic      rsp_digest_last;

   int mismatch_count;
   int digests_owed;
   int words_sent = 0;
   int digests_asked = 0;
   int long_holds_asked = 0;
   bit sender_calm = 1'b0;

   sha1_block_compression_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_message_word  (req_message_word),
      .req_message_start (req_message_start),
      .req_message_end   (req_message_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_digest_word   (rsp_digest_word),
      .rsp_digest_index  (rsp_digest_index),
      .rsp_digest_last   (rsp_digest_last)
   );

   sha1_block_compression_checker digest_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_message_word  (req_message_word),
      .req_message_start (req_message_start),
      .req_message_end   (req_message_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_digest_word   (rsp_digest_word),
      .rsp_digest_index  (rsp_digest_index),
      .rsp_digest_last   (rsp_digest_last),
      .mismatch_count    (mismatch_count),
      .digests_owed      (digests_owed)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #4_000_000;
      $display("tb failed");
      $finish;
   end

   task automatic send_word(word_type w, bit s, bit e);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_message_word  <= w;
      req_message_start <= s;
      req_message_end   <= e;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      if (e && (words_sent % 16) == 0) digests_asked++;
   endtask

   // Sends a message of whole blocks. Noisy messages scatter start and end
   // flags over the other words, including the last word of inner blocks.
   task automatic send_message(int blocks, bit with_start, bit with_end, bit noisy);
      int       b, p;
      bit       s, e;
      word_type w;
      sender_calm = ($urandom_range(0, 3) == 0);
      for (b = 0; b < blocks; b++) begin
         for (p = 0; p < 16; p++) begin
            case ($urandom_range(0, 15))
               0:       w = '0;
               1:       w = '1;
               default: w = $urandom;
            endcase
            s = (p == 0 && b == 0) ? with_start : (noisy && $urandom_range(0, 3) == 0);
            e = (p == 15 && b == blocks - 1) ? with_end
                                             : (noisy && $urandom_range(0, 3) == 0);
            send_word(w, s, e);
         end
      end
      sender_calm = 1'b0;
   endtask

   // The last item was just accepted, so valid drops before the next edge.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (digests_owed != 0) @(negedge clock);
   endtask

   // Result side: a random hold before each digest item, calm stretches with
   // no holds, and one long hold on request.
   initial begin : rsp_side
      int hold;
      int calm;
      int long_holds_done;
      calm = 0;
      long_holds_done = 0;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_holds_done < long_holds_asked) begin
            long_holds_done++;
            hold = 300;
         end else if (calm > 0) begin
            calm--;
            hold = 0;
         end else begin
            hold = $urandom_range(0, 5);
            if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 20);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin : req_side
      int p;
      int blocks;
      reset = 1'b1;
      req_valid = 1'b0;
      req_message_word = '0;
      req_message_start = 1'b0;
      req_message_end = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The first block after reset starts from the initial value even
      // without a start flag. Flags off their own positions are ignored.
      send_word(32'h0000_0000, 1'b0, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0, 1'b1);
      send_word(32'h0000_0000, 1'b1, 1'b0);
      send_word(32'hAAAA_AAAA, 1'b1, 1'b1);
      send_word(32'h5555_5555, 1'b0, 1'b0);
      for (p = 5; p < 15; p++)
         send_word($urandom, p[0], p[1]);
      send_word(32'hFFFF_FFFF, 1'b1, 1'b1);
      wait_drained();

      // A long receiver hold stalls the results, and with them the incoming blocks.
      long_holds_asked++;
      repeat (3) send_message(1, 1'b1, 1'b1, 1'b0);
      wait_drained();

      while (words_sent < 150 || digests_asked < 8) begin
         blocks = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
         send_message(blocks, $urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0,
                      $urandom_range(0, 4) == 0);
         if ($urandom_range(0, 5) == 0) wait_drained();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (100) @(negedge clock);
      if (mismatch_count == 0 && digests_owed == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
